// File: hdl/tsf_pkg.sv
// Shared types, constants and helper functions of the timestamp text formatter.
`default_nettype none
package tsf_pkg;

  localparam int unsigned TimeW    = 32;
  localparam int unsigned CharW    = 8;
  localparam int unsigned NumSlots = 14;

  // Reciprocals for the constant divisions, each with its post-shift.
  // secs = (t >> 3) * MulSec >> 36, mins = (secs >> 2) * MulMin >> 25,
  // hours = (mins >> 2) * MulHour >> 19.
  localparam logic [29:0] MulSec  = 30'd549755814;
  localparam logic [21:0] MulMin  = 22'd2236963;
  localparam logic [15:0] MulHour = 16'd34953;

  localparam logic [CharW-1:0] CharZero  = 8'h30;
  localparam logic [CharW-1:0] CharNine  = 8'h39;
  localparam logic [CharW-1:0] CharColon = 8'h3A;
  localparam logic [CharW-1:0] CharDot   = 8'h2E;

  typedef enum logic [1:0] {
    REG_PAD_LEVEL  = 2'd0,
    REG_CENTI_MODE = 2'd1,
    REG_DOT_SEP    = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic [1:0] pad_level;
    logic       centi_mode;
    logic       dot_separator;
  } cfg_t;

  typedef struct packed {
    logic [10:0] hours;
    logic [5:0]  min60;
    logic [5:0]  sec60;
    logic [9:0]  frac;
    logic        sec_ge60;
    logic        min_ge60;
  } split_t;

  typedef struct packed {
    logic [NumSlots-1:0][CharW-1:0] chars;
    logic [NumSlots-1:0]            show;
  } slots_t;

  // Split a value below 100 into tens and units digits.
  function automatic logic [7:0] bcd99(input logic [6:0] v);
    logic [3:0] tens;
    logic [6:0] units;
    tens = 4'd0;
    for (int i = 1; i < 10; i++) begin
      if (v >= 7'(10 * i)) begin
        tens = 4'(i);
      end
    end
    units = v - ({3'b000, tens} * 7'd10);
    return {tens, units[3:0]};
  endfunction

  function automatic logic [CharW-1:0] digit_char(input logic [3:0] d);
    return CharZero + {4'b0000, d};
  endfunction

endpackage
`default_nettype wire

// File: hdl/tsf_divide.sv
// Pipelined constant divisions: milliseconds into hours, minutes, seconds and fraction.
`default_nettype none
module tsf_divide (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [31:0]        time_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output tsf_pkg::split_t    out_o
);
  import tsf_pkg::*;

  logic v0_q, v1_q, v2_q, v3_q;
  logic en0, en1, en2, en3;

  logic [31:0] t0_q;
  logic [58:0] p1_d, p1_q;

  logic [22:0] secs;
  logic [31:0] frac_w;
  logic [42:0] p2_d, p2_q;
  logic [22:0] secs1_q;
  logic [9:0]  frac1_q;

  logic [16:0] mins;
  logic [22:0] sec_w;
  logic [30:0] p3_d, p3_q;
  logic [16:0] mins2_q;
  logic [5:0]  sec2_q;
  logic [9:0]  frac2_q;
  logic        sge2_q;

  logic [10:0] hours;
  logic [16:0] min_w;
  split_t      out_d, out_q;

  assign en3 = !v3_q || out_ready_i;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign en0 = !v0_q || en1;
  assign in_ready_o  = en0;
  assign out_valid_o = v3_q;
  assign out_o       = out_q;

  // stage 0: seconds reciprocal product
  assign p1_d = 59'(time_i[31:3]) * 59'(MulSec);

  // stage 1: seconds, fraction, minutes product
  assign secs   = p1_q[58:36];
  assign frac_w = t0_q - ({9'd0, secs} * 32'd1000);
  assign p2_d   = 43'(secs[22:2]) * 43'(MulMin);

  // stage 2: minutes, seconds of minute, hours product
  assign mins  = p2_q[41:25];
  assign sec_w = secs1_q - ({6'd0, mins} * 23'd60);
  assign p3_d  = 31'(mins[16:2]) * 31'(MulHour);

  // stage 3: hours, minutes of hour
  assign hours = p3_q[29:19];
  assign min_w = mins2_q - ({6'd0, hours} * 17'd60);

  always_comb begin
    out_d.hours    = hours;
    out_d.min60    = min_w[5:0];
    out_d.sec60    = sec2_q;
    out_d.frac     = frac2_q;
    out_d.sec_ge60 = sge2_q;
    out_d.min_ge60 = hours != 11'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en0) v0_q <= in_valid_i;
      if (en1) v1_q <= v0_q;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en0) begin
      t0_q <= time_i;
      p1_q <= p1_d;
    end
    if (en1) begin
      secs1_q <= secs;
      frac1_q <= frac_w[9:0];
      p2_q    <= p2_d;
    end
    if (en2) begin
      mins2_q <= mins;
      sec2_q  <= sec_w[5:0];
      frac2_q <= frac1_q;
      sge2_q  <= mins != 17'd0;
      p3_q    <= p3_d;
    end
    if (en3) begin
      out_q <= out_d;
    end
  end

endmodule
`default_nettype wire

// File: hdl/tsf_digits.sv
// Decimal digit extraction and character slot layout for one timestamp.
`default_nettype none
module tsf_digits (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  tsf_pkg::cfg_t      cfg_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  tsf_pkg::split_t    in_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output tsf_pkg::slots_t    out_o
);
  import tsf_pkg::*;

  logic        v_q, en;
  logic        hth_d, hth_q;
  logic [10:0] hsub;
  logic [9:0]  hr_d, hr_q;
  logic [15:0] hh_prod, fh_prod;
  logic [3:0]  hh_q, fh_q;
  logic [9:0]  frac_q;
  logic [5:0]  min60_q, sec60_q;
  logic        sge_q, mge_q;

  logic [9:0]  hrem, frem;
  logic [7:0]  hbcd, fbcd, mbcd, sbcd;
  logic        pad, show_h, show_m;

  assign en          = !v_q || out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = v_q;

  assign hth_d   = in_i.hours >= 11'd1000;
  assign hsub    = in_i.hours - 11'd1000;
  assign hr_d    = hth_d ? hsub[9:0] : in_i.hours[9:0];
  assign hh_prod = {6'd0, hr_d} * 16'd41;
  assign fh_prod = {6'd0, in_i.frac} * 16'd41;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (en) begin
      v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      hth_q   <= hth_d;
      hr_q    <= hr_d;
      hh_q    <= hh_prod[15:12];
      fh_q    <= fh_prod[15:12];
      frac_q  <= in_i.frac;
      min60_q <= in_i.min60;
      sec60_q <= in_i.sec60;
      sge_q   <= in_i.sec_ge60;
      mge_q   <= in_i.min_ge60;
    end
  end

  assign hrem = hr_q - ({6'd0, hh_q} * 10'd100);
  assign frem = frac_q - ({6'd0, fh_q} * 10'd100);
  assign hbcd = bcd99(hrem[6:0]);
  assign fbcd = bcd99(frem[6:0]);
  assign mbcd = bcd99({1'b0, min60_q});
  assign sbcd = bcd99({1'b0, sec60_q});

  assign pad    = cfg_i.pad_level != 2'd0;
  assign show_m = sge_q || pad;
  assign show_h = mge_q || cfg_i.pad_level[1];

  always_comb begin
    out_o.chars[0]  = digit_char({3'b000, hth_q});
    out_o.chars[1]  = digit_char(hh_q);
    out_o.chars[2]  = digit_char(hbcd[7:4]);
    out_o.chars[3]  = digit_char(hbcd[3:0]);
    out_o.chars[4]  = CharColon;
    out_o.chars[5]  = digit_char(mbcd[7:4]);
    out_o.chars[6]  = digit_char(mbcd[3:0]);
    out_o.chars[7]  = CharColon;
    out_o.chars[8]  = digit_char(sbcd[7:4]);
    out_o.chars[9]  = digit_char(sbcd[3:0]);
    out_o.chars[10] = cfg_i.dot_separator ? CharDot : CharColon;
    out_o.chars[11] = digit_char(fh_q);
    out_o.chars[12] = digit_char(fbcd[7:4]);
    out_o.chars[13] = digit_char(fbcd[3:0]);

    out_o.show[0]  = show_h && hth_q;
    out_o.show[1]  = show_h && (hth_q || hh_q != 4'd0);
    out_o.show[2]  = show_h && (hth_q || hh_q != 4'd0 || hrem[6:0] >= 7'd10);
    out_o.show[3]  = show_h;
    out_o.show[4]  = show_h;
    out_o.show[5]  = show_m && (pad || mge_q || min60_q >= 6'd10);
    out_o.show[6]  = show_m;
    out_o.show[7]  = show_m;
    out_o.show[8]  = pad || sge_q || sec60_q >= 6'd10;
    out_o.show[9]  = 1'b1;
    out_o.show[10] = 1'b1;
    out_o.show[11] = 1'b1;
    out_o.show[12] = 1'b1;
    out_o.show[13] = !cfg_i.centi_mode;
  end

endmodule
`default_nettype wire

// File: hdl/tsf_serializer.sv
// Character serializer: emits a timestamp's shown slots, one per cycle unless stalled.
`default_nettype none
module tsf_serializer (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  tsf_pkg::slots_t    in_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [7:0]         char_o,
  output logic               last_o
);
  import tsf_pkg::*;

  logic [NumSlots-1:0][CharW-1:0] chars_q;
  logic [NumSlots-1:0]            mask_d, mask_q;
  logic [NumSlots-1:0]            lowest, rest;
  logic                           busy, load, take;

  assign busy   = mask_q != '0;
  assign lowest = mask_q & (~mask_q + NumSlots'(1));
  assign rest   = mask_q & ~lowest;
  assign last_o = busy && (rest == '0);
  assign take   = busy && out_ready_i;
  assign load   = !busy || (take && last_o);

  assign in_ready_o  = load;
  assign out_valid_o = busy;

  always_comb begin
    char_o = '0;
    for (int i = 0; i < NumSlots; i++) begin
      char_o = char_o | (chars_q[i] & {CharW{lowest[i]}});
    end
  end

  always_comb begin
    mask_d = mask_q;
    if (load) begin
      mask_d = in_valid_i ? in_i.show : '0;
    end else if (take) begin
      mask_d = rest;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= '0;
    end else begin
      mask_q <= mask_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      chars_q <= in_i.chars;
    end
  end

endmodule
`default_nettype wire

// File: hdl/timestamp_text_formatter.sv
// Top level of the timestamp text formatter: config registers, pipeline and serializer.
//
//   channel   dir  handshake                 payload
//   s_axis    in   tvalid / tready           tdata[31:0] time_ms
//   m_axis    out  tvalid / tready           tdata[7:0] char_code, tlast last_char
//   cfg       in   cfg_we_i (no wait)        cfg_idx_i, cfg_wdata_i
//
// An item passes the divider and digit stages and leaves the serializer as 4 to 14
// characters, one per cycle unless stalled; the serializer sets the sustained rate.
// Five pipeline stages buffer items, so intake continues while characters wait.
// A stall on m_axis holds the current character; stages fill before s_axis stalls.
// Reset clears valids and sets pad_level 0, centi_mode 0, dot_separator 1.
`default_nettype none
module timestamp_text_formatter (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] time_ms
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] char_code
  output logic        m_axis_tlast,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [1:0]  cfg_wdata_i
);
  import tsf_pkg::*;

  cfg_t   cfg_q;
  split_t split;
  slots_t slots;
  logic   split_valid, split_ready;
  logic   slots_valid, slots_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pad_level     <= 2'd0;
      cfg_q.centi_mode    <= 1'b0;
      cfg_q.dot_separator <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_PAD_LEVEL:  cfg_q.pad_level     <= cfg_wdata_i;
        REG_CENTI_MODE: cfg_q.centi_mode    <= cfg_wdata_i[0];
        REG_DOT_SEP:    cfg_q.dot_separator <= cfg_wdata_i[0];
        default:        cfg_q               <= cfg_q;
      endcase
    end
  end

  tsf_divide u_divide (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .time_i      (s_axis_tdata),
    .out_valid_o (split_valid),
    .out_ready_i (split_ready),
    .out_o       (split)
  );

  tsf_digits u_digits (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (split_valid),
    .in_ready_o  (split_ready),
    .in_i        (split),
    .out_valid_o (slots_valid),
    .out_ready_i (slots_ready),
    .out_o       (slots)
  );

  tsf_serializer u_serializer (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (slots_valid),
    .in_ready_o  (slots_ready),
    .in_i        (slots),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .char_o      (m_axis_tdata),
    .last_o      (m_axis_tlast)
  );

  a_last_is_digit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tdata >= CharZero && m_axis_tdata <= CharNine)
    else $error("last character is not a digit");

  a_char_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata >= CharZero && m_axis_tdata <= CharNine) ||
                      m_axis_tdata == CharColon || m_axis_tdata == CharDot)
    else $error("illegal character code");

  a_stall_only_when_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("intake stalled with serializer idle");

  a_sep_not_first_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && m_axis_tlast ##1 m_axis_tvalid
      |-> m_axis_tdata >= CharZero && m_axis_tdata <= CharNine)
    else $error("timestamp starts with a separator");

endmodule
`default_nettype wire
